>>> src/dpc_pkg.sv
// shared types and constants of the dbscan point clusterer
package dpc_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int COORD_W    = 16;
  localparam int AXES       = 3;
  localparam int PT_W       = AXES * COORD_W;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SUM_W      = 35;
  localparam int MINNB_W    = 8;
  localparam int EPOCH_W    = CNT_W;
  localparam int CELL_LAT   = 2;
  localparam int CHAIN_LAT  = AXES * CELL_LAT;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SUM_W;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_RUN  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS_SQ   = 2'd0,
    REG_MIN_NB      = 2'd1,
    REG_POINT_COUNT = 2'd2,
    REG_MIN_KEPT    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]                cmd;
    logic [IDX_W-1:0]          slot_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       answer_kind;
    logic [CNT_W-1:0] clusters_found;
    logic [IDX_W-1:0] member_id;
    logic [IDX_W-1:0] cluster_number;
    logic             last_in_cluster;
    logic             list_end;
  } out_item_t;

  // data handed from one distance cell to the next
  typedef struct packed {
    logic [PT_W-1:0]  pt_a;
    logic [PT_W-1:0]  pt_b;
    logic [SUM_W-1:0] sum;
  } link_t;

endpackage

>>> src/dbscan_point_clusterer_core.sv
// load, read: one item in, load result the next cycle, a member read passes S_READ; one item at a time
// run: flag clearing over all MAX_POINTS entries, then per visited point one distance scan
// over the n points through memory read, chain and count, and a second scan for core points
// the scan rate is set by the single read port of the coordinate memory, one point a cycle
// reset clears control state and configuration; point and list memories hold data until written
module dbscan_point_clusterer_core import dpc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_READ      = 9'b000000010,
    S_CLEAR     = 9'b000000100,
    S_OUTER     = 9'b000001000,
    S_PT_CHK    = 9'b000010000,
    S_SCAN      = 9'b000100000,
    S_HEAD      = 9'b001000000,
    S_HEAD_WAIT = 9'b010000000,
    S_CLOSE     = 9'b100000000
  } state_e;

  typedef enum logic [1:0] {
    SK_COUNT    = 2'd0,
    SK_SEED_ENQ = 2'd1,
    SK_EXP_ENQ  = 2'd2
  } scan_e;

  // configuration
  logic [SUM_W-1:0]   radius_q;
  logic [MINNB_W-1:0] minnb_q;
  logic [CNT_W-1:0]   pcount_q;
  logic [CNT_W-1:0]   minkept_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= '0;
      minnb_q   <= MINNB_W'(1);
      pcount_q  <= '0;
      minkept_q <= CNT_W'(5);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_RADIUS_SQ:   radius_q  <= cfg_data_i[SUM_W-1:0];
        REG_MIN_NB:      minnb_q   <= cfg_data_i[MINNB_W-1:0];
        REG_POINT_COUNT: pcount_q  <= cfg_data_i[CNT_W-1:0];
        REG_MIN_KEPT:    minkept_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;
  scan_e  kind_q, kind_d;
  logic [CNT_W-1:0]   n_q, n_d, i_q, i_d, h_q, h_d, qlen_q, qlen_d;
  logic [CNT_W-1:0]   olen_q, olen_d, start_q, start_d, kept_q, kept_d, rp_q, rp_d;
  logic [CNT_W-1:0]   iss_q, iss_d, res_q, res_d, cnt_q, cnt_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic [IDX_W-1:0]   rcl_q, rcl_d, clr_q, clr_d, pt_q, pt_d, last_id_q, last_id_d;
  logic               seed_q, seed_d;
  logic [PT_W-1:0]    ref_q, ref_d;
  logic               iss_v_q, iss_v_d;
  logic [IDX_W-1:0]   iss_j_q;
  logic               out_v_q, out_v_d;
  out_item_t          out_q, out_d;

  // item tags travel beside the chain
  logic [CHAIN_LAT-1:0] tv_q, tc_q;
  logic [IDX_W-1:0]     tj_q [CHAIN_LAT];
  logic                 cand;

  // memories and their ports
  logic [PT_W-1:0]    coord_mem [MAX_POINTS];
  logic               vis_mem   [MAX_POINTS];
  logic [EPOCH_W-1:0] qm_mem    [MAX_POINTS];
  logic [IDX_W-1:0]   queue_mem [MAX_POINTS];
  logic [IDX_W:0]     om_mem    [MAX_POINTS];

  logic               coord_we, vis_we, vis_wdata, qm_we, qu_we, om_we;
  logic [IDX_W-1:0]   pt_raddr, vis_waddr, qm_waddr, om_waddr;
  logic [EPOCH_W-1:0] qm_wdata;
  logic [IDX_W:0]     om_wdata;
  logic [PT_W-1:0]    coord_rd_q;
  logic               vis_rd_q;
  logic [EPOCH_W-1:0] qm_rd_q;
  logic [IDX_W-1:0]   queue_rd_q;
  logic [IDX_W:0]     om_rd_q;

  always_ff @(posedge clk_i) begin
    if (coord_we) begin
      coord_mem[in_item_i.slot_index] <= {in_item_i.coord_z, in_item_i.coord_y,
                                          in_item_i.coord_x};
    end
    coord_rd_q <= coord_mem[pt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    vis_rd_q <= vis_mem[pt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (qm_we) begin
      qm_mem[qm_waddr] <= qm_wdata;
    end
    qm_rd_q <= qm_mem[iss_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (qu_we) begin
      queue_mem[qlen_q[IDX_W-1:0]] <= tj_q[CHAIN_LAT-1];
    end
    queue_rd_q <= queue_mem[h_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (om_we) begin
      om_mem[om_waddr] <= om_wdata;
    end
    om_rd_q <= om_mem[rp_q[IDX_W-1:0]];
  end

  // distance chain, one cell per axis
  link_t chain [AXES+1];
  assign chain[0].pt_a = ref_q;
  assign chain[0].pt_b = coord_rd_q;
  assign chain[0].sum  = '0;

  for (genvar k = 0; k < AXES; k++) begin : g_cell
    dpc_dist_cell u_cell (
      .clk_i  (clk_i),
      .link_i (chain[k]),
      .link_o (chain[k+1])
    );
  end

  // candidate for expansion: not visited and not yet queued in this cluster
  assign cand = !vis_rd_q && (qm_rd_q != epoch_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q <= '0;
    end else begin
      tv_q <= {tv_q[CHAIN_LAT-2:0], iss_v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    tc_q    <= {tc_q[CHAIN_LAT-2:0], cand};
    tj_q[0] <= iss_j_q;
    for (int k = 1; k < CHAIN_LAT; k++) begin
      tj_q[k] <= tj_q[k-1];
    end
    iss_j_q <= iss_q[IDX_W-1:0];
  end

  logic in_acc, res_v, near, enq;
  logic [CNT_W-1:0] csize;

  assign in_ready_o = (state_q == S_IDLE) && (!out_v_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;
  assign res_v      = tv_q[CHAIN_LAT-1];
  assign near       = chain[AXES].sum <= radius_q;
  assign csize      = olen_q - start_q;

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    n_d       = n_q;
    i_d       = i_q;
    h_d       = h_q;
    qlen_d    = qlen_q;
    olen_d    = olen_q;
    start_d   = start_q;
    kept_d    = kept_q;
    rp_d      = rp_q;
    iss_d     = iss_q;
    res_d     = res_q;
    cnt_d     = cnt_q;
    epoch_d   = epoch_q;
    rcl_d     = rcl_q;
    clr_d     = clr_q;
    pt_d      = pt_q;
    last_id_d = last_id_q;
    seed_d    = seed_q;
    ref_d     = ref_q;
    iss_v_d   = 1'b0;
    out_v_d   = out_v_q;
    out_d     = out_q;
    coord_we  = 1'b0;
    vis_we    = 1'b0;
    vis_waddr = pt_q;
    vis_wdata = 1'b1;
    qm_we     = 1'b0;
    qm_waddr  = tj_q[CHAIN_LAT-1];
    qm_wdata  = epoch_q;
    qu_we     = 1'b0;
    om_we     = 1'b0;
    om_waddr  = olen_q[IDX_W-1:0];
    om_wdata  = {1'b0, pt_q};
    enq       = 1'b0;

    unique case (state_q)
      S_OUTER:     pt_raddr = i_q[IDX_W-1:0];
      S_HEAD_WAIT: pt_raddr = queue_rd_q;
      default:     pt_raddr = iss_q[IDX_W-1:0];
    endcase

    if (out_v_q && out_ready_i) begin
      out_v_d = 1'b0;
    end

    // results leaving the distance chain
    if (res_v) begin
      res_d = res_q + CNT_W'(1);
      unique case (kind_q)
        SK_COUNT:    cnt_d = near ? cnt_q + CNT_W'(1) : cnt_q;
        SK_SEED_ENQ: enq = near;
        SK_EXP_ENQ:  enq = near && tc_q[CHAIN_LAT-1];
        default: ;
      endcase
      if (enq) begin
        qu_we  = 1'b1;
        qm_we  = 1'b1;
        qlen_d = qlen_q + CNT_W'(1);
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          out_d                = '0;
          out_d.answer_kind    = in_item_i.cmd;
          out_d.clusters_found = kept_q;
          unique case (cmd_e'(in_item_i.cmd))
            CMD_LOAD: begin
              coord_we = 1'b1;
              out_v_d  = 1'b1;
            end
            CMD_RUN: begin
              n_d     = (pcount_q > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : pcount_q;
              olen_d  = '0;
              rp_d    = '0;
              kept_d  = '0;
              rcl_d   = '0;
              epoch_d = '0;
              clr_d   = '0;
              state_d = S_CLEAR;
            end
            CMD_READ: begin
              if (rp_q < olen_q) begin
                state_d = S_READ;
              end else begin
                out_d.list_end = 1'b1;
                out_v_d        = 1'b1;
              end
            end
            default: out_v_d = 1'b1;
          endcase
        end
      end
      S_READ: begin
        out_d.member_id       = om_rd_q[IDX_W-1:0];
        out_d.cluster_number  = rcl_q;
        out_d.last_in_cluster = om_rd_q[IDX_W];
        rcl_d   = rcl_q + IDX_W'(om_rd_q[IDX_W]);
        rp_d    = rp_q + CNT_W'(1);
        out_v_d = 1'b1;
        state_d = S_IDLE;
      end
      S_CLEAR: begin
        vis_we    = 1'b1;
        vis_waddr = clr_q;
        vis_wdata = 1'b0;
        qm_we     = 1'b1;
        qm_waddr  = clr_q;
        qm_wdata  = '0;
        clr_d     = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(MAX_POINTS - 1)) begin
          i_d     = '0;
          state_d = S_OUTER;
        end
      end
      S_OUTER: begin
        if (i_q >= n_q) begin
          out_d                = '0;
          out_d.answer_kind    = CMD_RUN;
          out_d.clusters_found = kept_q;
          out_v_d              = 1'b1;
          state_d              = S_IDLE;
        end else begin
          pt_d    = i_q[IDX_W-1:0];
          seed_d  = 1'b1;
          state_d = S_PT_CHK;
        end
      end
      S_PT_CHK: begin
        if (vis_rd_q) begin
          if (seed_q) begin
            i_d     = i_q + CNT_W'(1);
            state_d = S_OUTER;
          end else begin
            h_d     = h_q + CNT_W'(1);
            state_d = S_HEAD;
          end
        end else begin
          vis_we = 1'b1;
          ref_d  = coord_rd_q;
          if (!seed_q) begin
            om_we     = 1'b1;
            olen_d    = olen_q + CNT_W'(1);
            last_id_d = pt_q;
          end
          iss_d   = '0;
          res_d   = '0;
          cnt_d   = '0;
          kind_d  = SK_COUNT;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (iss_q < n_q) begin
          iss_d   = iss_q + CNT_W'(1);
          iss_v_d = 1'b1;
        end
        if (res_q == n_q) begin
          iss_d = '0;
          res_d = '0;
          unique case (kind_q)
            SK_COUNT: begin
              if (cnt_q >= CNT_W'(minnb_q)) begin
                if (seed_q) begin
                  // core seed opens a cluster
                  epoch_d   = epoch_q + EPOCH_W'(1);
                  start_d   = olen_q;
                  om_we     = 1'b1;
                  olen_d    = olen_q + CNT_W'(1);
                  last_id_d = pt_q;
                  qlen_d    = '0;
                  h_d       = '0;
                  kind_d    = SK_SEED_ENQ;
                end else begin
                  kind_d = SK_EXP_ENQ;
                end
              end else if (seed_q) begin
                i_d     = i_q + CNT_W'(1);
                state_d = S_OUTER;
              end else begin
                h_d     = h_q + CNT_W'(1);
                state_d = S_HEAD;
              end
            end
            SK_SEED_ENQ: state_d = S_HEAD;
            default: begin
              h_d     = h_q + CNT_W'(1);
              state_d = S_HEAD;
            end
          endcase
        end
      end
      S_HEAD: begin
        state_d = (h_q < qlen_q) ? S_HEAD_WAIT : S_CLOSE;
      end
      S_HEAD_WAIT: begin
        pt_d    = queue_rd_q;
        seed_d  = 1'b0;
        state_d = S_PT_CHK;
      end
      S_CLOSE: begin
        if (csize >= minkept_q) begin
          om_we    = 1'b1;
          om_waddr = IDX_W'(olen_q - CNT_W'(1));
          om_wdata = {1'b1, last_id_q};
          kept_d   = kept_q + CNT_W'(1);
        end else begin
          olen_d = start_q;
        end
        i_d     = i_q + CNT_W'(1);
        state_d = S_OUTER;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      kind_q    <= SK_COUNT;
      n_q       <= '0;
      i_q       <= '0;
      h_q       <= '0;
      qlen_q    <= '0;
      olen_q    <= '0;
      start_q   <= '0;
      kept_q    <= '0;
      rp_q      <= '0;
      iss_q     <= '0;
      res_q     <= '0;
      cnt_q     <= '0;
      epoch_q   <= '0;
      rcl_q     <= '0;
      clr_q     <= '0;
      pt_q      <= '0;
      last_id_q <= '0;
      seed_q    <= 1'b0;
      iss_v_q   <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      kind_q    <= kind_d;
      n_q       <= n_d;
      i_q       <= i_d;
      h_q       <= h_d;
      qlen_q    <= qlen_d;
      olen_q    <= olen_d;
      start_q   <= start_d;
      kept_q    <= kept_d;
      rp_q      <= rp_d;
      iss_q     <= iss_d;
      res_q     <= res_d;
      cnt_q     <= cnt_d;
      epoch_q   <= epoch_d;
      rcl_q     <= rcl_d;
      clr_q     <= clr_d;
      pt_q      <= pt_d;
      last_id_q <= last_id_d;
      seed_q    <= seed_d;
      iss_v_q   <= iss_v_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ref_q <= ref_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

>>> src/dpc_dist_cell.sv
// one axis cell of the squared distance chain
module dpc_dist_cell import dpc_pkg::*; (
  input  logic  clk_i,
  input  link_t link_i,
  output link_t link_o
);

  logic signed [DIFF_W-1:0]   diff_d;
  logic signed [DIFF_W-1:0]   diff_q;
  link_t                      mid_q;
  link_t                      out_q;
  logic signed [2*DIFF_W-1:0] sq;

  assign diff_d = $signed({link_i.pt_a[COORD_W-1], link_i.pt_a[COORD_W-1:0]})
                - $signed({link_i.pt_b[COORD_W-1], link_i.pt_b[COORD_W-1:0]});
  assign sq = diff_q * diff_q;

  always_ff @(posedge clk_i) begin
    diff_q      <= diff_d;
    // lowest axis is used here, the rest moves down for the next cell
    mid_q.pt_a  <= link_i.pt_a >> COORD_W;
    mid_q.pt_b  <= link_i.pt_b >> COORD_W;
    mid_q.sum   <= link_i.sum;
    out_q.pt_a  <= mid_q.pt_a;
    out_q.pt_b  <= mid_q.pt_b;
    out_q.sum   <= mid_q.sum + SUM_W'($unsigned(sq));
  end

  assign link_o = out_q;

endmodule
